@@ hw/rtl/bounded_double_ended_queue_top_assert.svh @@
// Assertion macros used by the deque datapath.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BDQ_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bdq assertion failed");

// Next-cycle implication, checked out of reset.
`define BDQ_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bdq assertion failed");

`endif

@@ hw/rtl/bdq_pkg.sv @@
`default_nettype none

package bdq_pkg;

    localparam int DEPTH   = 256;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // one extra bit so an index can sit at minus one
    localparam int IDX_W   = ADDR_W + 1;
    localparam int DATA_W  = 32;

    localparam logic [IDX_W-1:0] IDX_NONE = '1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

    localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
    localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [1:0] REQ_POP_REAR   = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_ROOM = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;

    typedef struct packed {
        logic start;   // request beat accepted this cycle
        logic load;    // move pending result into the output register
    } bdq_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/bounded_double_ended_queue_top.sv @@
`default_nettype none

// Bounded deque of 256 signed 32-bit elements on a linear array: pushes and
// pops at either end, one result beat per request beat, carrying the popped
// value (zero unless a pop succeeds), a status (ok, no room, empty) and the
// empty and full flags after the request. The array does not wrap: a push at
// either end is refused once the rear reaches the last slot, and a front push
// is refused while no slot lies ahead of the front. For each request, the
// accept cycle does the single memory access and index update, and a load
// step then moves the registered read data into the output register once
// that register is free. No new request is taken until the previous one has
// loaded; a stalled result blocks only the request after the next one. Memory
// content is not cleared at reset, and reset empties the deque at once.
module bounded_double_ended_queue_top
    import bdq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] push_value
    input  wire logic [7:0]  s_tuser,   // [1:0] req_type, [7:2] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] pop_value
    output logic [7:0]       m_tuser    // [1:0] status, [2] is_empty, [3] is_full, [7:4] zero
);

    bdq_cmd_t          cmd;
    logic [DATA_W-1:0] pop_value;
    logic [1:0]        status;
    logic              is_empty;
    logic              is_full;

    bdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    bdq_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .req_type   (s_tuser[1:0]),
        .push_value (s_tdata),
        .pop_value  (pop_value),
        .status     (status),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

    assign m_tdata = pop_value;
    assign m_tuser = {4'b0000, is_full, is_empty, status};

endmodule

`default_nettype wire

@@ hw/rtl/bdq_ctrl.sv @@
`default_nettype none

module bdq_ctrl
    import bdq_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output bdq_cmd_t      cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        cmd.start = s_tvalid && (state_reg == ST_IDLE);
        cmd.load  = (state_reg == ST_RUN) && (!out_valid_reg || m_tready);

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // wait here while the output register still holds an untaken beat
                if (cmd.load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        priority if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bdq_datapath.sv @@
`default_nettype none

module bdq_datapath
    import bdq_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bdq_cmd_t          cmd,
    input  wire logic [1:0]        req_type,
    input  wire logic [DATA_W-1:0] push_value,
    output logic [DATA_W-1:0]      pop_value,
    output logic [1:0]             status,
    output logic                   is_empty,
    output logic                   is_full
);

    `include "bounded_double_ended_queue_top_assert.svh"

    logic [DATA_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0]  front_reg, front_next;
    logic [IDX_W-1:0]  rear_reg, rear_next;
    logic [DATA_W-1:0] rd_data_reg;

    // result of the request in flight, held until the output register frees
    logic              pop_ok_reg;
    logic [1:0]        stat_reg;
    logic              empty_reg;
    logic              full_reg;

    logic [DATA_W-1:0] pop_value_reg;
    logic [1:0]        status_reg;
    logic              is_empty_reg;
    logic              is_full_reg;

    logic              full_now, empty_now;
    logic              wr_en, rd_en, pop_ok;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        stat;
    logic [IDX_W-1:0]  front_inc, rear_inc;

    always_comb begin
        full_now   = (rear_reg == IDX_LAST);
        empty_now  = (front_reg == rear_reg);
        front_inc  = front_reg + IDX_W'(1);
        rear_inc   = rear_reg + IDX_W'(1);
        front_next = front_reg;
        rear_next  = rear_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        pop_ok     = 1'b0;
        stat       = STAT_OK;
        addr       = front_reg[ADDR_W-1:0];

        unique case (req_type)
            REQ_PUSH_FRONT: begin
                addr = front_reg[ADDR_W-1:0];
                // no slot ahead of the front while it sits at minus one
                if (full_now || front_reg[IDX_W-1]) begin
                    stat = STAT_NO_ROOM;
                end else begin
                    wr_en      = cmd.start;
                    front_next = front_reg - IDX_W'(1);
                end
            end
            REQ_PUSH_REAR: begin
                addr = rear_inc[ADDR_W-1:0];
                if (full_now) begin
                    stat = STAT_NO_ROOM;
                end else begin
                    wr_en     = cmd.start;
                    rear_next = rear_inc;
                end
            end
            REQ_POP_FRONT: begin
                addr = front_inc[ADDR_W-1:0];
                if (empty_now) begin
                    stat = STAT_EMPTY;
                end else begin
                    rd_en      = cmd.start;
                    pop_ok     = 1'b1;
                    front_next = front_inc;
                end
            end
            REQ_POP_REAR: begin
                addr = rear_reg[ADDR_W-1:0];
                if (empty_now) begin
                    stat = STAT_EMPTY;
                end else begin
                    rd_en     = cmd.start;
                    pop_ok    = 1'b1;
                    rear_next = rear_reg - IDX_W'(1);
                end
            end
            default: stat = STAT_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= push_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= IDX_NONE;
            rear_reg  <= IDX_NONE;
        end else if (cmd.start) begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            pop_ok_reg <= pop_ok;
            stat_reg   <= stat;
            empty_reg  <= (front_next == rear_next);
            full_reg   <= (rear_next == IDX_LAST);
        end
        if (cmd.load) begin
            pop_value_reg <= pop_ok_reg ? rd_data_reg : '0;
            status_reg    <= stat_reg;
            is_empty_reg  <= empty_reg;
            is_full_reg   <= full_reg;
        end
    end

    assign pop_value = pop_value_reg;
    assign status    = status_reg;
    assign is_empty  = is_empty_reg;
    assign is_full   = is_full_reg;

    `BDQ_ASSERT_IMP(a_front_not_past_rear, aclk, aresetn, 1'b1, $signed(front_reg) <= $signed(rear_reg))
    `BDQ_ASSERT_NXT(a_idx_hold_when_idle, aclk, aresetn, !cmd.start, $stable(front_reg) && $stable(rear_reg))
    `BDQ_ASSERT_NXT(a_one_end_moves, aclk, aresetn, cmd.start, (front_reg == $past(front_reg)) || (rear_reg == $past(rear_reg)))

endmodule

`default_nettype wire
